FILE: sv/binary_min_heap_queue_defines.svh
// Assertion macros used by the heap queue port checker.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define HMQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("heap queue check failed");

// Checked on every rising clock edge, reset included.
`define HMQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("heap queue check failed");

`endif

FILE: sv/hmq_pkg.sv
// Types and constants of the binary min-heap queue.
`timescale 1ns / 1ps

package hmq_pkg;

  localparam int KEY_W        = 16;
  localparam int PAY_W        = 16;
  localparam int COUNT_OUT_W  = 10;
  localparam int CAPACITY_DEF = 512;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] new_key;
    logic        [PAY_W-1:0] new_payload;
  } in_word_t;

  typedef struct packed {
    status_e                       status;
    logic signed [KEY_W-1:0]       removed_key;
    logic        [PAY_W-1:0]       removed_payload;
    logic                          min_valid;
    logic signed [KEY_W-1:0]       min_key;
    logic        [COUNT_OUT_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } entry_t;

endpackage

FILE: sv/hmq_store.sv
// Heap entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module hmq_store #(
  parameter int DEPTH = hmq_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  hmq_pkg::entry_t          wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output hmq_pkg::entry_t          rdata_o
);

  hmq_pkg::entry_t mem_q [DEPTH];
  hmq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/hmq_ctrl.sv
// Sift sequencer: walks the heap one level at a time through a single compare unit.
`timescale 1ns / 1ps

module hmq_ctrl #(
  parameter int CAPACITY = hmq_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hmq_pkg::in_word_t           in_data_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output hmq_pkg::out_word_t          res_data_o,
  output logic                        mem_we_o,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr_o,
  output hmq_pkg::entry_t             mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr_o,
  input  hmq_pkg::entry_t             mem_rdata_i
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_RD    = 8'b0000_0010,
    S_UP_CMP   = 8'b0000_0100,
    S_LAST_WT  = 8'b0000_1000,
    S_DN_RD    = 8'b0001_0000,
    S_DN_LEFT  = 8'b0010_0000,
    S_DN_RIGHT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [IW-1:0]        pos_q, pos_d;
  hmq_pkg::entry_t      cur_q, cur_d;
  hmq_pkg::entry_t      child_q, child_d;
  logic                 left_q, left_d;
  hmq_pkg::entry_t      root_q, root_d;
  hmq_pkg::status_e     status_q, status_d;
  hmq_pkg::entry_t      removed_q, removed_d;

  logic [XW-1:0]        lc_x, rc_x, cnt_x;
  logic                 lc_in, rc_in;
  logic [IW-1:0]        lc_idx, rc_idx, parent_idx;
  logic signed [hmq_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic                 cmp_lt;

  // Child and parent positions; children are checked against the count in wider arithmetic.
  assign lc_x       = {1'b0, pos_q, 1'b1};
  assign rc_x       = lc_x + XW'(1);
  assign cnt_x      = XW'(count_q);
  assign lc_in      = lc_x < cnt_x;
  assign rc_in      = rc_x < cnt_x;
  assign lc_idx     = lc_x[IW-1:0];
  assign rc_idx     = rc_x[IW-1:0];
  assign parent_idx = (pos_q - IW'(1)) >> 1;

  // The one shared signed comparator.
  always_comb begin
    cmp_a = mem_rdata_i.key;
    cmp_b = cur_q.key;
    if (state_q == S_UP_CMP) begin
      cmp_a = cur_q.key;
      cmp_b = mem_rdata_i.key;
    end else if (state_q == S_DN_RIGHT && left_q) begin
      cmp_b = child_q.key;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    child_d     = child_q;
    left_d      = left_q;
    status_d    = status_q;
    removed_d   = removed_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = cur_q;
    mem_raddr_o = lc_idx;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d  = hmq_pkg::ST_DONE;
          removed_d = '0;
          if (in_data_i.cmd == hmq_pkg::CMD_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = hmq_pkg::ST_FULL;
              state_d  = S_DONE;
            end else begin
              pos_d       = IW'(count_q);
              cur_d.key   = in_data_i.new_key;
              cur_d.payload = in_data_i.new_payload;
              count_d     = count_q + CW'(1);
              state_d     = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = hmq_pkg::ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              removed_d   = root_q;
              count_d     = count_q - CW'(1);
              pos_d       = '0;
              mem_raddr_o = IW'(count_q - CW'(1));
              state_d     = (count_q == CW'(1)) ? S_DONE : S_LAST_WT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = S_DONE;
        end else begin
          mem_raddr_o = parent_idx;
          state_d     = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we_o = 1'b1;
        if (cmp_lt) begin
          // Parent is strictly greater: it moves down into the hole.
          mem_wdata_o = mem_rdata_i;
          pos_d       = parent_idx;
          state_d     = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_LAST_WT: begin
        cur_d   = mem_rdata_i;
        state_d = S_DN_RD;
      end

      S_DN_RD: begin
        if (lc_in) begin
          state_d = S_DN_LEFT;
        end else begin
          mem_we_o = 1'b1;
          state_d  = S_DONE;
        end
      end

      S_DN_LEFT: begin
        if (rc_in) begin
          child_d     = mem_rdata_i;
          left_d      = cmp_lt;
          mem_raddr_o = rc_idx;
          state_d     = S_DN_RIGHT;
        end else begin
          mem_we_o = 1'b1;
          if (cmp_lt) begin
            mem_wdata_o = mem_rdata_i;
            pos_d       = lc_idx;
            state_d     = S_DN_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_DN_RIGHT: begin
        mem_we_o = 1'b1;
        // The right child wins only when strictly smaller than the best so far.
        if (cmp_lt) begin
          mem_wdata_o = mem_rdata_i;
          pos_d       = rc_idx;
          state_d     = S_DN_RD;
        end else if (left_q) begin
          mem_wdata_o = child_q;
          pos_d       = lc_idx;
          state_d     = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The root is mirrored in a register so the minimum is known without a memory read.
  always_comb begin
    root_d = root_q;
    if (mem_we_o && mem_waddr_o == '0) begin
      root_d = mem_wdata_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    child_q   <= child_d;
    left_q    <= left_d;
    root_q    <= root_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_data_o.status          = status_q;
    res_data_o.removed_key     = removed_q.key;
    res_data_o.removed_payload = removed_q.payload;
    res_data_o.min_valid       = (count_q != '0);
    res_data_o.min_key         = (count_q != '0) ? root_q.key : '0;
    res_data_o.entry_count     = hmq_pkg::COUNT_OUT_W'(count_q);
  end

endmodule

FILE: sv/binary_min_heap_queue.sv
// Top level of the binary min-heap queue: sequencer, entry memory and output register.
//
//   channel   direction   handshake                 word
//   input     in          in_valid_i / in_ready_o   in_data_i  (hmq_pkg::in_word_t)
//   output    out         out_valid_o / out_ready_i out_data_o (hmq_pkg::out_word_t)
//
// An insert sifts up and a remove sifts down over the levels the entry moves; each level
// costs a read of the single read port plus a compare, and a remove reads the left and
// right child apart. Rejected words and the removal of the last entry skip the sift.
// One word is in work at a time; a finished result sits in the output register, so the
// next word is taken while it waits to be read. A full output register holds the
// sequencer until it is read. Reset clears the entry count, the sequencer state and the
// output valid flag; the memory needs no clearing pass.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
  parameter int CAPACITY = hmq_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hmq_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hmq_pkg::out_word_t out_data_o
);

  localparam int IW = $clog2(CAPACITY);

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  hmq_pkg::entry_t      mem_wdata, mem_rdata;
  logic                 res_valid, res_ready;
  hmq_pkg::out_word_t   res_data;
  logic                 out_valid_q, out_valid_d;
  hmq_pkg::out_word_t   out_data_q;

  hmq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  hmq_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/hmq_checker.sv
// Port-level checks of the heap queue, bound to the top level.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_defines.svh"

module hmq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input hmq_pkg::in_word_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hmq_pkg::out_word_t out_data_o
);

  // A stalled result word holds.
  `HMQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // Only one word is in work: the input closes right after a word is taken.
  `HMQ_ASSERT(a_one_in_work, in_valid_i && in_ready_o |=> !in_ready_o)

  // A nonzero count always comes with a valid minimum.
  `HMQ_ASSERT(a_count_min, out_valid_o && out_data_o.entry_count != '0 |-> out_data_o.min_valid)

  // An empty heap shows a zero minimum key and a zero count.
  `HMQ_ASSERT(a_empty_zero,
              out_valid_o && !out_data_o.min_valid |->
              out_data_o.min_key == '0 && out_data_o.entry_count == '0)

  // A rejected word carries no removed entry.
  `HMQ_ASSERT(a_reject_clean,
              out_valid_o && out_data_o.status != hmq_pkg::ST_DONE |->
              out_data_o.removed_key == '0 && out_data_o.removed_payload == '0)

endmodule

bind binary_min_heap_queue hmq_checker u_checker (.*);

FILE: bench/heap_queue_checker.sv
// Checker for the binary min-heap queue: predicts every result and compares it.
`timescale 1ns / 1ps

module heap_queue_checker #(
  parameter int CAPACITY = hmq_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  hmq_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  hmq_pkg::out_word_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  import hmq_pkg::*;

  logic signed [KEY_W-1:0] heap_key [CAPACITY];
  logic        [PAY_W-1:0] heap_pay [CAPACITY];
  int unsigned             heap_size = 0;

  out_word_t awaited_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: heap queue mismatch on %s: got %0h, expected %0h",
             $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Applies one command word to the shadow heap and builds the result word.
  task automatic heap_apply(input in_word_t w, output out_word_t r);
    int unsigned             pos;
    int unsigned             up;
    int unsigned             best;
    int unsigned             lc;
    int unsigned             rc;
    logic signed [KEY_W-1:0] tmp_key;
    logic        [PAY_W-1:0] tmp_pay;
    bit                      settled;
    r = '0;
    r.status = ST_DONE;
    if (w.cmd == CMD_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_size;
        heap_size++;
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          up = (pos - 1) / 2;
          if (heap_key[up] > w.new_key) begin
            heap_key[pos] = heap_key[up];
            heap_pay[pos] = heap_pay[up];
            pos = up;
          end else begin
            settled = 1'b1;
          end
        end
        heap_key[pos] = w.new_key;
        heap_pay[pos] = w.new_payload;
      end
    end else begin
      if (heap_size == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_key     = heap_key[0];
        r.removed_payload = heap_pay[0];
        heap_size--;
        if (heap_size > 0) begin
          heap_key[0] = heap_key[heap_size];
          heap_pay[0] = heap_pay[heap_size];
          pos = 0;
          settled = 1'b0;
          // Sift down to the strictly smaller child; the left child wins a tie.
          while (!settled) begin
            best = pos;
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            if (lc < heap_size && heap_key[lc] < heap_key[best]) best = lc;
            if (rc < heap_size && heap_key[rc] < heap_key[best]) best = rc;
            if (best == pos) begin
              settled = 1'b1;
            end else begin
              tmp_key        = heap_key[pos];
              tmp_pay        = heap_pay[pos];
              heap_key[pos]  = heap_key[best];
              heap_pay[pos]  = heap_pay[best];
              heap_key[best] = tmp_key;
              heap_pay[best] = tmp_pay;
              pos = best;
            end
          end
        end
      end
    end
    r.min_valid   = (heap_size > 0);
    r.min_key     = (heap_size > 0) ? heap_key[0] : '0;
    r.entry_count = heap_size[COUNT_OUT_W-1:0];
  endtask

  // The result word is registered, so a result never leaves at the edge that
  // takes its own command word; the output side is handled first.
  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t predicted;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result word", out_data_i[31:0], '0);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", out_data_i.status, want.status);
          check_field("removed_key", out_data_i.removed_key, want.removed_key);
          check_field("removed_payload", out_data_i.removed_payload,
                      want.removed_payload);
          check_field("min_valid", out_data_i.min_valid, want.min_valid);
          check_field("min_key", out_data_i.min_key, want.min_key);
          check_field("entry_count", out_data_i.entry_count, want.entry_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        heap_apply(in_data_i, predicted);
        awaited_results.push_back(predicted);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

FILE: bench/tb_binary_min_heap_queue.sv
// Testbench top of the binary min-heap queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;

  import hmq_pkg::*;

  localparam int HEAP_CAP = CAPACITY_DEF;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_data_o;

  int fail_count;
  int pending;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  int heap_level   = 0;

  always #6 clk_i = ~clk_i;

  binary_min_heap_queue #(
    .CAPACITY(HEAP_CAP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  heap_queue_checker #(
    .CAPACITY(HEAP_CAP)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: random stalls, or a long hold-off counted down here.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic in_word_t make_word(input logic cmd, input logic [15:0] key,
                                         input logic [15:0] pay);
    in_word_t w;
    w.cmd         = cmd;
    w.new_key     = key;
    w.new_payload = pay;
    return w;
  endfunction

  // Keys lean toward a few close values so that ties and equal siblings occur.
  function automatic logic [15:0] random_key();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return 16'($urandom_range(4)) - 16'd2;
    if (pick < 30) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic in_word_t random_word(input int insert_pct);
    logic cmd;
    cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
    return make_word(cmd, random_key(), 16'($urandom));
  endfunction

  // Offers one word and returns at the edge that accepts it; valid stays high
  // so that a following word can go out back to back.
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (w.cmd == CMD_INSERT && heap_level < HEAP_CAP) heap_level++;
    if (w.cmd == CMD_REMOVE && heap_level > 0) heap_level--;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_mixed(input int n, input int tx, input int rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    repeat (n) send_word(random_word(55));
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty remove, key extremes, ties at the root and among siblings.
    send_word(make_word(CMD_REMOVE, 16'h0000, 16'h0000));
    send_word(make_word(CMD_INSERT, 16'h7fff, 16'hffff));
    send_word(make_word(CMD_INSERT, 16'h8000, 16'h0000));
    send_word(make_word(CMD_INSERT, 16'h0000, 16'h1234));
    send_word(make_word(CMD_INSERT, 16'hffff, 16'h0001));
    send_word(make_word(CMD_INSERT, 16'h0001, 16'h8000));
    send_word(make_word(CMD_INSERT, 16'h0000, 16'haaaa));
    send_word(make_word(CMD_INSERT, 16'h8000, 16'h5555));
    repeat (8) send_word(make_word(CMD_REMOVE, 16'hffff, 16'hffff));
    for (int i = 0; i < 4; i++) send_word(make_word(CMD_INSERT, 16'h0100, 16'(i)));
    repeat (4) send_word(make_word(CMD_REMOVE, 16'h0000, 16'h0000));
    wait_drained();

    // The receiver holds off while words keep coming, so the input stalls.
    hold_left = 300;
    repeat (24) send_word(random_word(70));
    wait_drained();

    // Fill to capacity and beyond; the mixed runs below then work on a deep heap.
    tx_idle_pct  = 62;
    rx_stall_pct = 0;
    while (heap_level < HEAP_CAP) send_word(random_word(96));
    repeat (12) send_word(random_word(80));
    wait_drained();

    run_mixed(55, 0, 0);
    run_mixed(55, 62, 0);
    run_mixed(55, 0, 62);
    run_mixed(55, 27, 27);

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("binary_min_heap_queue regression: pass");
    end else begin
      $display("binary_min_heap_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("binary_min_heap_queue regression: fail");
    $finish;
  end

endmodule
